@@ sv/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg
// Types, codes and the dance move table of the stepper pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int MOVE_COUNT_DEF   = 20;
  localparam int TICKS_PER_MS_DEF = 1000;
  localparam int SETTLE_TICKS_DEF = 5;

  localparam int TimeW = 20;
  localparam int DelayW = 12;

  localparam logic [11:0] START_DELAY_RST    = 12'd2000;
  localparam logic [11:0] DEFAULT_TARGET_RST = 12'd700;
  localparam logic [7:0]  RAMP_STEP_RST      = 8'd4;
  localparam logic [11:0] MIN_TARGET_RST     = 12'd150;

  // input command codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_FASTER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_START_DELAY    = 2'd0;
  localparam logic [1:0] CFG_DEFAULT_TARGET = 2'd1;
  localparam logic [1:0] CFG_RAMP_STEP      = 2'd2;
  localparam logic [1:0] CFG_MIN_TARGET     = 2'd3;

  typedef enum logic [1:0] {
    MODE_STILL   = 2'd0,
    MODE_ROUTINE = 2'd1,
    MODE_RAMP    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    PH_SETTLE = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2,
    PH_PAUSE  = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] new_mode;
  } in_item_t;

  typedef struct packed {
    logic        step_level;
    logic        dir_level;
    logic [1:0]  mode_now;
    logic [11:0] target_now;
    logic        refused;
  } out_item_t;

  typedef struct packed {
    logic        ccw;
    logic [8:0]  steps;
    logic [11:0] half;
    logic [9:0]  pause_ms;
  } move_t;

  // Dance routine; entries past the given twenty are empty moves.
  function automatic move_t move_rom_f(input logic [4:0] idx);
    move_t m;
    m = '0;
    case (idx)
      5'd0:  m = '{1'b0, 9'd40,  12'd600,  10'd60};
      5'd1:  m = '{1'b1, 9'd40,  12'd600,  10'd60};
      5'd2:  m = '{1'b0, 9'd40,  12'd600,  10'd60};
      5'd3:  m = '{1'b1, 9'd40,  12'd600,  10'd120};
      5'd4:  m = '{1'b0, 9'd100, 12'd400,  10'd200};
      5'd5:  m = '{1'b1, 9'd50,  12'd1400, 10'd250};
      5'd6:  m = '{1'b0, 9'd12,  12'd700,  10'd40};
      5'd7:  m = '{1'b1, 9'd12,  12'd700,  10'd40};
      5'd8:  m = '{1'b0, 9'd12,  12'd700,  10'd40};
      5'd9:  m = '{1'b1, 9'd12,  12'd700,  10'd40};
      5'd10: m = '{1'b0, 9'd12,  12'd700,  10'd40};
      5'd11: m = '{1'b1, 9'd12,  12'd700,  10'd200};
      5'd12: m = '{1'b0, 9'd8,   12'd500,  10'd25};
      5'd13: m = '{1'b1, 9'd8,   12'd500,  10'd25};
      5'd14: m = '{1'b0, 9'd8,   12'd500,  10'd25};
      5'd15: m = '{1'b1, 9'd8,   12'd500,  10'd25};
      5'd16: m = '{1'b0, 9'd8,   12'd500,  10'd25};
      5'd17: m = '{1'b1, 9'd8,   12'd500,  10'd250};
      5'd18: m = '{1'b0, 9'd300, 12'd450,  10'd300};
      5'd19: m = '{1'b1, 9'd300, 12'd450,  10'd600};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

@@ sv/stepper_pulse_sequencer_with_ramp.sv @@
// ----------------------------------------------------------------------------
// stepper_pulse_sequencer_with_ramp
// Step/direction generator with a fixed dance routine and a speed ramp.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one beat is a microsecond tick, a set-mode command or a
//                 faster command (in_valid_i / in_ready_o / in_data_i).
//   out channel : exactly one beat per input beat, holding the step and
//                 direction levels, mode, smooth target and refused flag
//                 after that input (out_valid_o / out_ready_i / out_data_o).
//   cfg port    : user writes it only while the block is idle; not enforced.
// The beat is applied to the drive state and the result lands in the output
// register at the same edge. Throughput is one beat per cycle while the
// receiver is ready, set by that single register stage; the input is taken
// whenever the output register is empty or being drained at the same edge.
// Reset puts the block in idle mode with pins low and the config registers
// at their defaults. While the receiver stalls, the result holds and the
// input is not taken, so no microsecond tick is lost; time stands still.
// ----------------------------------------------------------------------------
module stepper_pulse_sequencer_with_ramp
  import sps_pkg::*;
#(
  parameter int MOVE_COUNT   = MOVE_COUNT_DEF,
  parameter int TICKS_PER_MS = TICKS_PER_MS_DEF,
  parameter int SETTLE_TICKS = SETTLE_TICKS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [11:0] cfg_wdata_i
);

  localparam logic [5:0] MoveCnt = 6'(MOVE_COUNT);
  localparam logic [TimeW-1:0] SettleLoad = TimeW'(SETTLE_TICKS);
  localparam move_t FirstMove = move_rom_f(5'd0);

  logic [11:0] start_delay_q, default_target_q, min_target_q;
  logic [7:0]  ramp_step_q;

  mode_e             mode_q, mode_d;
  phase_e            phase_q, phase_d;
  logic [11:0]       target_q, target_d;
  logic [11:0]       ramp_q, ramp_d;
  logic              active_q, active_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [4:0]        idx_q, idx_d;
  logic [8:0]        steps_q, steps_d;
  logic              step_q, step_d;
  logic              dir_q, dir_d;
  logic [11:0]       half_q, half_d;
  logic              smooth_q, smooth_d;

  logic       out_valid_q;
  out_item_t  out_data_q;
  logic       in_fire;
  logic       refused;

  move_t             cur_move, next_move;
  logic [4:0]        idx_next;
  logic [5:0]        idx_inc;
  logic [TimeW-1:0]  pause_cur, pause_next;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_inc   = {1'b0, idx_q} + 6'd1;
  assign idx_next  = (idx_inc >= MoveCnt) ? 5'd0 : idx_inc[4:0];
  assign cur_move  = move_rom_f(idx_q);
  assign next_move = move_rom_f(idx_next);
  assign pause_cur  = TimeW'(32'(cur_move.pause_ms) * 32'(TICKS_PER_MS));
  assign pause_next = TimeW'(32'(next_move.pause_ms) * 32'(TICKS_PER_MS));

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delay_q    <= START_DELAY_RST;
      default_target_q <= DEFAULT_TARGET_RST;
      ramp_step_q      <= RAMP_STEP_RST;
      min_target_q     <= MIN_TARGET_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_DELAY:    start_delay_q    <= cfg_wdata_i;
        CFG_DEFAULT_TARGET: default_target_q <= cfg_wdata_i;
        CFG_RAMP_STEP:      ramp_step_q      <= cfg_wdata_i[7:0];
        CFG_MIN_TARGET:     min_target_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TimeW-1:0] tc_dec;
    logic [11:0]      hp;
    logic [11:0]      diff;
    logic [11:0]      halved;
    logic [8:0]       steps_dec;

    mode_d   = mode_q;
    phase_d  = phase_q;
    target_d = target_q;
    ramp_d   = ramp_q;
    active_d = active_q;
    time_d   = time_q;
    idx_d    = idx_q;
    steps_d  = steps_q;
    step_d   = step_q;
    dir_d    = dir_q;
    half_d   = half_q;
    smooth_d = smooth_q;
    refused  = 1'b0;

    tc_dec    = (time_q != '0) ? time_q - TimeW'(1) : '0;
    hp        = '0;
    diff      = ramp_q - target_q;
    halved    = {1'b0, target_q[11:1]};
    steps_dec = (steps_q != '0) ? steps_q - 9'd1 : '0;

    if (in_fire) begin
      case (in_data_i.func)
        FUNC_TICK: begin
          if (phase_q == PH_HIGH || phase_q == PH_LOW) begin
            time_d = tc_dec;
            if (tc_dec == '0) begin
              if (phase_q == PH_HIGH) begin
                step_d  = 1'b0;
                phase_d = PH_LOW;
                time_d  = TimeW'(half_q);
              end else if (smooth_q) begin
                // end of a smooth step: ramp toward the target
                if (ramp_q > target_q) begin
                  if (diff < {4'd0, ramp_step_q}) ramp_d = target_q;
                  else ramp_d = ramp_q - {4'd0, ramp_step_q};
                end
                phase_d = PH_SETTLE;
                time_d  = '0;
              end else begin
                steps_d = steps_dec;
                if (steps_dec == '0) begin
                  phase_d = PH_PAUSE;
                  time_d  = pause_cur;
                end else begin
                  phase_d = PH_SETTLE;
                  time_d  = '0;
                end
              end
            end
          end else if (mode_q == MODE_STILL) begin
            active_d = 1'b0;
            step_d   = 1'b0;
            phase_d  = PH_SETTLE;
            time_d   = '0;
          end else if (!active_q) begin
            active_d = 1'b1;
            step_d   = 1'b0;
            idx_d    = 5'd0;
            phase_d  = PH_SETTLE;
            time_d   = SettleLoad;
            if (mode_q == MODE_ROUTINE) begin
              dir_d   = FirstMove.ccw;
              steps_d = FirstMove.steps;
            end else begin
              dir_d   = 1'b0;
              ramp_d  = start_delay_q;
              steps_d = '0;
            end
          end else if (time_q != '0) begin
            time_d = tc_dec;
          end else if (phase_q == PH_PAUSE && mode_q == MODE_ROUTINE) begin
            idx_d   = idx_next;
            dir_d   = next_move.ccw;
            steps_d = next_move.steps;
            phase_d = PH_SETTLE;
            time_d  = SettleLoad;
          end else if (mode_q == MODE_ROUTINE && steps_q == '0) begin
            // empty move goes straight to its pause
            phase_d = PH_PAUSE;
            time_d  = pause_cur;
          end else begin
            if (mode_q == MODE_ROUTINE) begin
              hp       = cur_move.half;
              smooth_d = 1'b0;
            end else begin
              hp       = ramp_q;
              smooth_d = 1'b1;
            end
            if (hp == '0) hp = 12'd1;
            half_d  = hp;
            step_d  = 1'b1;
            phase_d = PH_HIGH;
            time_d  = TimeW'(hp);
          end
        end
        FUNC_SET: begin
          if (in_data_i.new_mode <= MODE_RAMP) begin
            mode_d   = mode_e'(in_data_i.new_mode);
            active_d = 1'b0;
            if (in_data_i.new_mode == MODE_RAMP) target_d = default_target_q;
          end
        end
        FUNC_FASTER: begin
          if (mode_q != MODE_RAMP) refused = 1'b1;
          else target_d = (halved < min_target_q) ? min_target_q : halved;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_STILL;
      phase_q     <= PH_SETTLE;
      target_q    <= DEFAULT_TARGET_RST;
      ramp_q      <= START_DELAY_RST;
      active_q    <= 1'b0;
      time_q      <= '0;
      idx_q       <= '0;
      steps_q     <= '0;
      step_q      <= 1'b0;
      dir_q       <= 1'b0;
      half_q      <= 12'd1;
      smooth_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      target_q <= target_d;
      ramp_q   <= ramp_d;
      active_q <= active_d;
      time_q   <= time_d;
      idx_q    <= idx_d;
      steps_q  <= steps_d;
      step_q   <= step_d;
      dir_q    <= dir_d;
      half_q   <= half_d;
      smooth_q <= smooth_d;
      if (in_fire) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q.step_level <= step_d;
      out_data_q.dir_level  <= dir_d;
      out_data_q.mode_now   <= mode_d;
      out_data_q.target_now <= target_d;
      out_data_q.refused    <= refused;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_refused_not_smooth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.refused |-> out_data_o.mode_now != MODE_RAMP)
    else $error("refused beat reported in smooth mode");

  a_step_high_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q |-> phase_q == PH_HIGH)
    else $error("step pin high outside the high phase");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted beat produced no result");
`endif

endmodule

@@ tb/sv/stepper_pulse_sequencer_with_ramp_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_pulse_sequencer_with_ramp_tb
// Self-checking bench for the stepper pulse sequencer.
// A cycle-accurate software copy of the drive state follows every accepted
// command beat and queues the pin and status levels it should produce. Each
// result beat is checked against the oldest queued entry. Directed tests
// cover the commands, the ramp, the half-period extremes and the start of
// the dance routine; random phases under several register settings mix mode
// changes, ticks and faster commands, with bursty input and a stalling
// receiver.
// ----------------------------------------------------------------------------
module stepper_pulse_sequencer_with_ramp_tb;
  import sps_pkg::*;

  localparam int MOVES = MOVE_COUNT_DEF;
  localparam int MS_TICKS = TICKS_PER_MS_DEF;
  localparam logic [19:0] SETTLE = 20'(SETTLE_TICKS_DEF);
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 40000;
  localparam int PRINT_CAP = 50;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_item_t   in_data_i;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_data_o;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [11:0] cfg_wdata_i;

  stepper_pulse_sequencer_with_ramp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // drive state copy
  logic [11:0] cfg_start, cfg_default, cfg_min;
  logic [7:0]  cfg_ramp;
  mode_e       mode_q;
  phase_e      ph_q;
  logic [11:0] tgt_q, ramp_q, half_q;
  logic [19:0] cnt_q;
  logic [4:0]  move_q;
  logic [8:0]  left_q;
  logic        running_q, smooth_step_q, pin_step, pin_dir;

  out_item_t pending_levels_q[$];

  int mismatches = 0;
  int beats_sent = 0;
  int beats_seen = 0;
  int regs_written = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int max_gap = 0;
  int stall_pct = 0;
  int hold_left = 0;

  function automatic void reset_model();
    cfg_start = START_DELAY_RST;
    cfg_default = DEFAULT_TARGET_RST;
    cfg_ramp = RAMP_STEP_RST;
    cfg_min = MIN_TARGET_RST;
    mode_q = MODE_STILL;
    ph_q = PH_SETTLE;
    tgt_q = DEFAULT_TARGET_RST;
    ramp_q = START_DELAY_RST;
    half_q = 12'd1;
    cnt_q = '0;
    move_q = '0;
    left_q = '0;
    running_q = 1'b0;
    smooth_step_q = 1'b0;
    pin_step = 1'b0;
    pin_dir = 1'b0;
  endfunction

  // dance table: direction alternates, odd entries counterclockwise
  function automatic move_t dance_move(logic [4:0] idx);
    move_t m;
    m = '0;
    if (idx < 20) m.ccw = idx[0];
    if (idx < 4) begin
      m.steps = 9'd40;  m.half = 12'd600;  m.pause_ms = (idx == 3) ? 10'd120 : 10'd60;
    end else if (idx == 4) begin
      m.steps = 9'd100; m.half = 12'd400;  m.pause_ms = 10'd200;
    end else if (idx == 5) begin
      m.steps = 9'd50;  m.half = 12'd1400; m.pause_ms = 10'd250;
    end else if (idx < 12) begin
      m.steps = 9'd12;  m.half = 12'd700;  m.pause_ms = (idx == 11) ? 10'd200 : 10'd40;
    end else if (idx < 18) begin
      m.steps = 9'd8;   m.half = 12'd500;  m.pause_ms = (idx == 17) ? 10'd250 : 10'd25;
    end else if (idx < 20) begin
      m.steps = 9'd300; m.half = 12'd450;  m.pause_ms = (idx == 18) ? 10'd300 : 10'd600;
    end
    return m;
  endfunction

  function automatic logic [19:0] pause_ticks(move_t m);
    return 20'(m.pause_ms * MS_TICKS);
  endfunction

  function automatic void load_move();
    move_t m;
    m = dance_move(move_q);
    pin_dir = m.ccw;
    left_q = m.steps;
    ph_q = PH_SETTLE;
    cnt_q = SETTLE;
  endfunction

  function automatic void advance_tick();
    move_t m;
    logic [11:0] hp;
    m = dance_move(move_q);
    if (ph_q == PH_HIGH || ph_q == PH_LOW) begin
      if (cnt_q != 0) cnt_q = cnt_q - 1;
      if (cnt_q != 0) return;
      if (ph_q == PH_HIGH) begin
        pin_step = 1'b0;
        ph_q = PH_LOW;
        cnt_q = 20'(half_q);
      end else if (smooth_step_q) begin
        if (ramp_q > tgt_q)
          ramp_q = (ramp_q - tgt_q < 12'(cfg_ramp)) ? tgt_q : ramp_q - 12'(cfg_ramp);
        ph_q = PH_SETTLE;
        cnt_q = '0;
      end else begin
        if (left_q != 0) left_q = left_q - 1;
        if (left_q == 0) begin
          ph_q = PH_PAUSE;
          cnt_q = pause_ticks(m);
        end else begin
          ph_q = PH_SETTLE;
          cnt_q = '0;
        end
      end
      return;
    end
    // no step under way: the mode is acted on here
    if (mode_q == MODE_STILL) begin
      running_q = 1'b0;
      pin_step = 1'b0;
      ph_q = PH_SETTLE;
      cnt_q = '0;
      return;
    end
    if (!running_q) begin
      running_q = 1'b1;
      pin_step = 1'b0;
      move_q = '0;
      if (mode_q == MODE_ROUTINE) begin
        load_move();
      end else begin
        pin_dir = 1'b0;
        ramp_q = cfg_start;
        left_q = '0;
        ph_q = PH_SETTLE;
        cnt_q = SETTLE;
      end
      return;
    end
    if (cnt_q != 0) begin
      cnt_q = cnt_q - 1;
      return;
    end
    if (ph_q == PH_PAUSE && mode_q == MODE_ROUTINE) begin
      move_q = (move_q + 1 >= MOVES) ? 5'd0 : move_q + 5'd1;
      load_move();
      return;
    end
    if (mode_q == MODE_ROUTINE) begin
      if (left_q == 0) begin
        ph_q = PH_PAUSE;
        cnt_q = pause_ticks(m);
        return;
      end
      hp = m.half;
      smooth_step_q = 1'b0;
    end else begin
      hp = ramp_q;
      smooth_step_q = 1'b1;
    end
    if (hp == 0) hp = 12'd1;
    half_q = hp;
    pin_step = 1'b1;
    ph_q = PH_HIGH;
    cnt_q = 20'(hp);
  endfunction

  function automatic out_item_t apply_command(in_item_t it);
    out_item_t r;
    logic [11:0] halved;
    r = '0;
    case (it.func)
      FUNC_TICK: advance_tick();
      FUNC_SET: begin
        if (it.new_mode != MODE_UNUSED) begin
          mode_q = mode_e'(it.new_mode);
          running_q = 1'b0;
          if (mode_q == MODE_RAMP) tgt_q = cfg_default;
        end
      end
      FUNC_FASTER: begin
        if (mode_q != MODE_RAMP) begin
          r.refused = 1'b1;
        end else begin
          halved = tgt_q >> 1;
          tgt_q = (halved < cfg_min) ? cfg_min : halved;
        end
      end
      default: ;
    endcase
    r.step_level = pin_step;
    r.dir_level = pin_dir;
    r.mode_now = mode_q;
    r.target_now = tgt_q;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // receiver: ready with occasional stalls of random length
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if ($urandom_range(99, 0) < stall_pct) begin
      out_ready_i <= 1'b0;
      hold_left <= $urandom_range(5, 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      beats_seen++;
      if (pending_levels_q.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_levels_q.pop_front();
        if (out_data_o.step_level !== want.step_level)
          report_mismatch($sformatf("step_level got %b want %b",
                                    out_data_o.step_level, want.step_level));
        if (out_data_o.dir_level !== want.dir_level)
          report_mismatch($sformatf("dir_level got %b want %b",
                                    out_data_o.dir_level, want.dir_level));
        if (out_data_o.mode_now !== want.mode_now)
          report_mismatch($sformatf("mode_now got %0d want %0d",
                                    out_data_o.mode_now, want.mode_now));
        if (out_data_o.target_now !== want.target_now)
          report_mismatch($sformatf("target_now got %0d want %0d",
                                    out_data_o.target_now, want.target_now));
        if (out_data_o.refused !== want.refused)
          report_mismatch($sformatf("refused got %b want %b",
                                    out_data_o.refused, want.refused));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_cnt, pending_levels_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t beat_of(logic [1:0] f, logic [1:0] m);
    in_item_t r;
    r.func = f;
    r.new_mode = m;
    return r;
  endfunction

  function automatic in_item_t tick_beat();
    return beat_of(FUNC_TICK, 2'($urandom_range(3, 0)));
  endfunction

  // one command beat; input idles between random bursts
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = (max_gap == 0) ? 0 : $urandom_range(max_gap, 0);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_levels_q.push_back(apply_command(it));
    beats_sent++;
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_item(tick_beat());
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_START_DELAY:    cfg_start = val;
      CFG_DEFAULT_TARGET: cfg_default = val;
      CFG_RAMP_STEP:      cfg_ramp = val[7:0];
      CFG_MIN_TARGET:     cfg_min = val;
      default: ;
    endcase
    regs_written++;
  endtask

  task automatic set_regs(logic [11:0] sd, logic [11:0] dt, logic [7:0] rs, logic [11:0] mt);
    write_reg(CFG_START_DELAY, sd);
    write_reg(CFG_DEFAULT_TARGET, dt);
    write_reg(CFG_RAMP_STEP, {4'b0, rs});
    write_reg(CFG_MIN_TARGET, mt);
    cfg_we_i <= 1'b0;
  endtask

  // reset values: every command, unused codes, refusal, target floor
  task automatic test_commands();
    max_gap = 3;
    stall_pct <= 30;
    send_item(beat_of(FUNC_TICK, MODE_UNUSED));
    send_item(beat_of(FUNC_UNUSED, MODE_UNUSED));
    send_item(beat_of(FUNC_SET, MODE_UNUSED));
    send_item(beat_of(FUNC_FASTER, MODE_STILL));
    send_item(beat_of(FUNC_SET, MODE_ROUTINE));
    send_item(beat_of(FUNC_FASTER, MODE_RAMP));
    send_item(beat_of(FUNC_TICK, MODE_STILL));
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    repeat (4) send_item(beat_of(FUNC_FASTER, MODE_ROUTINE));
    send_item(beat_of(FUNC_TICK, MODE_RAMP));
    send_item(beat_of(FUNC_SET, MODE_STILL));
    send_item(beat_of(FUNC_TICK, MODE_ROUTINE));
    send_item(beat_of(FUNC_UNUSED, MODE_STILL));
    send_item(beat_of(FUNC_FASTER, MODE_UNUSED));
  endtask

  // short half-periods: ramp clamps at the target, step finishes after idle
  task automatic test_smooth_ramp();
    wait_quiet();
    set_regs(12'd9, 12'd4, 8'd3, 12'd1);
    max_gap = 4;
    stall_pct <= 20;
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    run_ticks(50);
    send_item(beat_of(FUNC_FASTER, MODE_STILL));
    run_ticks(25);
    repeat (2) send_item(beat_of(FUNC_FASTER, MODE_STILL));
    run_ticks(15);
    // restart, then drop to idle while the first step is high
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    run_ticks(9);
    send_item(beat_of(FUNC_SET, MODE_STILL));
    run_ticks(20);
  endtask

  // zero half-period runs as one tick; target may halve to zero
  task automatic test_zero_half();
    wait_quiet();
    set_regs(12'd0, 12'd0, 8'd1, 12'd0);
    max_gap = 2;
    stall_pct <= 40;
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    run_ticks(30);
    send_item(beat_of(FUNC_FASTER, MODE_RAMP));
    run_ticks(10);
    send_item(beat_of(FUNC_SET, MODE_STILL));
    run_ticks(5);
  endtask

  task automatic test_register_extremes();
    wait_quiet();
    set_regs(12'hFFF, 12'hFFF, 8'hFF, 12'hFFF);
    max_gap = 2;
    stall_pct <= 10;
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    send_item(beat_of(FUNC_FASTER, MODE_STILL));
    run_ticks(60);
    send_item(beat_of(FUNC_SET, MODE_STILL));
    run_ticks(5);
  endtask

  // dance start: routine start, settle and the first step; then a restart,
  // a smooth command and idle while that step is still under way
  task automatic test_dance_walk();
    wait_quiet();
    set_regs(START_DELAY_RST, DEFAULT_TARGET_RST, RAMP_STEP_RST, MIN_TARGET_RST);
    max_gap = 0;
    stall_pct <= 0;
    send_item(beat_of(FUNC_SET, MODE_ROUTINE));
    for (int i = 0; i < 60; i++) begin
      if (i == 30) begin
        send_item(beat_of(FUNC_FASTER, MODE_RAMP));
        send_item(beat_of(FUNC_UNUSED, MODE_ROUTINE));
      end
      if (i == 40) stall_pct <= 5;
      send_item(tick_beat());
    end
    send_item(beat_of(FUNC_SET, MODE_ROUTINE));
    run_ticks(20);
    send_item(beat_of(FUNC_SET, MODE_RAMP));
    run_ticks(20);
    send_item(beat_of(FUNC_SET, MODE_STILL));
    run_ticks(10);
  endtask

  task automatic test_random_mix();
    int made;
    int kind;
    int run;
    in_item_t it;
    for (int p = 0; p < 4; p++) begin
      wait_quiet();
      case (p)
        0: set_regs(12'($urandom_range(16, 1)), 12'($urandom_range(8, 1)),
                    8'($urandom_range(4, 1)), 12'($urandom_range(4, 1)));
        1: set_regs(12'd1, 12'd1, 8'd1, 12'd1);
        2: set_regs(12'($urandom_range(60, 1)), 12'($urandom_range(60, 1)),
                    8'($urandom_range(255, 1)), 12'($urandom_range(30, 1)));
        default: set_regs(12'($urandom_range(30, 1)), 12'($urandom_range(30, 1)),
                          8'hFF, 12'hFFF);
      endcase
      max_gap = $urandom_range(6, 0);
      stall_pct <= (p == 1) ? 0 : $urandom_range(60, 0);
      made = 0;
      while (made < 40) begin
        kind = $urandom_range(99, 0);
        if (kind < 50) begin
          // mode command followed by a run of ticks with some faster beats
          send_item(beat_of(FUNC_SET, (kind < 35) ? MODE_RAMP :
                                      (kind < 43) ? MODE_ROUTINE : MODE_STILL));
          run = $urandom_range(40, 5);
          repeat (run) begin
            if ($urandom_range(9, 0) == 0)
              send_item(beat_of(FUNC_FASTER, 2'($urandom_range(3, 0))));
            else
              send_item(tick_beat());
          end
          made += run + 1;
        end else if (kind < 80) begin
          run = $urandom_range(30, 1);
          run_ticks(run);
          made += run;
        end else if (kind < 90) begin
          send_item(beat_of(FUNC_FASTER, 2'($urandom_range(3, 0))));
          made++;
        end else begin
          it = beat_of(2'($urandom_range(3, 0)), 2'($urandom_range(3, 0)));
          send_item(it);
          if (it.func != FUNC_UNUSED && !(it.func == FUNC_SET && it.new_mode == MODE_UNUSED))
            made++;
        end
      end
    end
  endtask

  initial begin
    reset_model();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_START_DELAY;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_commands();
    test_smooth_ramp();
    test_zero_half();
    test_register_extremes();
    test_dance_walk();
    test_random_mix();
    wait_quiet();
    $display("covered %0d command beats, %0d result beats, %0d register writes in %0d cycles",
             beats_sent, beats_seen, regs_written, cycle_cnt);
    $display("modes, faster floor, ramp clamp, zero half-period and first dance step seen;"
             , " %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
